[rtl/cdeq_pkg.sv]
// Shared types and constants for the circular double-ended queue.
// No dependencies; imported by every module of the block.
package cdeq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int CMD_W              = 2;
   localparam int STATUS_W           = 2;
   localparam int CSR_W              = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_EMPTY      = 2'd2,
      STATUS_UNUSED     = 2'd3
   } status_type;

   // per-cycle move applied to every cell of the row
   typedef struct packed {
      logic shift_in_front;  // push at the front: every word moves one cell back
      logic shift_to_front;  // pop at the front: every word moves one cell forward
      logic append;          // push at the back: the cell just past the last word loads
   } cell_ctrl_type;

endpackage

[rtl/cdeq_cell.sv]
// One word cell of the queue row; loads from either neighbour or the pushed word.
// Depends on cdeq_pkg.
module cdeq_cell #(
   parameter int DATA_WIDTH = cdeq_pkg::DATA_WIDTH_DEFAULT,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  cdeq_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]        fill_count,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   input  logic [DATA_WIDTH-1:0]   push_data,
   output logic [DATA_WIDTH-1:0]   data_out
);
   import cdeq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic                  here;

   assign here     = (fill_count == CNT_W'(INDEX));
   assign data_out = data_ff;

   always_ff @(posedge clock) begin
      priority if (ctrl.shift_in_front) begin
         data_ff <= left_data;
      end else if (ctrl.shift_to_front) begin
         data_ff <= right_data;
      end else if (ctrl.append && here) begin
         data_ff <= push_data;
      end else begin
         data_ff <= data_ff;
      end
   end

endmodule

[rtl/circular_double_ended_queue.sv]
// Top level of the double-ended queue: command handling, fill count and a row of cells.
// Depends on cdeq_pkg and cdeq_cell.
//
// For each command, busy rises on the cycle after start is taken, the row of cells moves on
// that same edge, and the result is shown for that one busy cycle with rsp_strobe high,
// read straight from the front cell and the cell just below the fill count. No new command
// is taken while busy is high, so each result is shown before the next command is taken. The receiver
// cannot stall; results must be taken on the strobe. Writing the capacity register empties
// the queue; a value of 0 is taken as 1 and a value above DEPTH as DEPTH.
module circular_double_ended_queue #(
   parameter int DEPTH      = cdeq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdeq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cdeq_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [DATA_WIDTH-1:0]        req_value,
   output logic                                rsp_strobe,
   output logic [cdeq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [DATA_WIDTH-1:0]        rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]        rsp_back_value,
   output logic                                rsp_is_full,
   output logic                                rsp_is_empty,
   input  logic                                csr_wr_en,
   input  logic [cdeq_pkg::CSR_W-1:0]          csr_wr_data
);
   import cdeq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      capacity_ff, capacity_in;
   logic                  pending_ff;
   status_type            status_ff, status_in;

   logic                  accept;
   logic                  full_now, empty_now;
   cmd_type               cmd;
   cell_ctrl_type         ctrl;
   logic [CMP_W-1:0]      wr_wide;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] back_word;

   assign accept    = start && !pending_ff;
   assign cmd       = cmd_type'(req_cmd);
   assign full_now  = (count_ff >= capacity_ff);
   assign empty_now = (count_ff == '0);
   assign wr_wide   = CMP_W'(csr_wr_data);

   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      if (accept) begin
         unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (full_now) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.shift_in_front = (cmd == CMD_PUSH_FRONT);
                  ctrl.append         = (cmd == CMD_PUSH_BACK);
                  count_in            = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
               if (empty_now) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  ctrl.shift_to_front = (cmd == CMD_POP_FRONT);
                  count_in            = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr_en) begin
         priority if (wr_wide == '0) begin
            capacity_in = CNT_W'(1);
         end else if (wr_wide > CMP_W'(DEPTH)) begin
            capacity_in = CNT_W'(DEPTH);
         end else begin
            capacity_in = CNT_W'(wr_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= CNT_W'(DEPTH);
         pending_ff  <= 1'b0;
         status_ff   <= STATUS_DONE;
      end else begin
         pending_ff  <= accept;
         capacity_ff <= capacity_in;
         if (accept) begin
            status_ff <= status_in;
         end
         if (csr_wr_en) begin
            count_ff <= '0;
         end else begin
            count_ff <= count_in;
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      if (i == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = req_value;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      cdeq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .fill_count (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .push_data  (req_value),
         .data_out   (cell_data[i])
      );
   end

   // last word sits in the cell just below the fill count
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CNT_W'(i + 1)) begin
            back_word = back_word | cell_data[i];
         end
      end
   end

   assign busy            = pending_ff;
   assign rsp_strobe      = pending_ff;
   assign rsp_status      = status_ff;
   assign rsp_is_empty    = empty_now;
   assign rsp_is_full     = (count_ff == capacity_ff);
   assign rsp_front_value = empty_now ? '1 : cell_data[0];
   assign rsp_back_value  = empty_now ? '1 : back_word;

endmodule
